### sv/ipv_pkg.sv
// Shared types, character codes and helper functions for the address text validator.
package ipv_pkg;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 2;

   localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_V4   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_V6   = 2'd2;

   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LO_F  = 8'h66;
   localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UP_F  = 8'h46;

   localparam logic [2:0] DOT_SAT     = 3'd4;
   localparam logic [2:0] DOT_GOOD    = 3'd3;
   localparam logic [3:0] COLON_SAT   = 4'd8;
   localparam logic [3:0] COLON_GOOD  = 4'd7;
   localparam logic [2:0] V4_LEN_MAX  = 3'd3;
   localparam logic [2:0] V4_LEN_SAT  = 3'd4;
   localparam logic [2:0] V6_LEN_MAX  = 3'd4;
   localparam logic [2:0] V6_LEN_SAT  = 3'd5;
   localparam logic [9:0] V4_VAL_MAX  = 10'd255;

   typedef struct packed {
      logic [2:0] dot_count;
      logic       seen_dot;
      logic [2:0] v4_group_len;
      logic [9:0] v4_group_value;
      logic       v4_leading_zero;
      logic       v4_bad;
      logic [3:0] colon_count;
      logic [2:0] v6_group_len;
      logic       v6_bad;
   } ipv_state_type;

   function automatic logic is_dec(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic is_hex(input logic [CHAR_W-1:0] c);
      return is_dec(c) || ((c >= CHAR_LO_A) && (c <= CHAR_LO_F))
             || ((c >= CHAR_UP_A) && (c <= CHAR_UP_F));
   endfunction

   function automatic logic v4_group_bad(input logic [2:0] len, input logic lz,
                                         input logic [9:0] val);
      return (len == 3'd0) || (len > V4_LEN_MAX) || (lz && (len > 3'd1))
             || (val > V4_VAL_MAX);
   endfunction

   function automatic logic v6_group_bad(input logic [2:0] len);
      return (len == 3'd0) || (len > V6_LEN_MAX);
   endfunction

endpackage

### sv/ipv_scan.sv
// Scan state registers with the per-character update and the end-of-string verdict.
module ipv_scan (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_en,
   input  logic [ipv_pkg::CHAR_W-1:0]     char_in,
   input  logic                           is_last,
   output logic [ipv_pkg::KIND_W-1:0]     kind
);

   ipv_pkg::ipv_state_type state_ff;
   ipv_pkg::ipv_state_type state_in;
   ipv_pkg::ipv_state_type upd;
   logic [3:0]             digit;
   logic                   v4_bad_final;
   logic                   v6_bad_final;

   assign digit = char_in[3:0];

   always_comb begin
      upd = state_ff;
      if (char_in == ipv_pkg::CHAR_DOT) begin
         upd.seen_dot = 1'b1;
         if (state_ff.dot_count < ipv_pkg::DOT_SAT) begin
            upd.dot_count = state_ff.dot_count + 3'd1;
         end
         upd.v4_bad = state_ff.v4_bad
                      | ipv_pkg::v4_group_bad(state_ff.v4_group_len,
                                              state_ff.v4_leading_zero,
                                              state_ff.v4_group_value);
         upd.v4_group_len    = 3'd0;
         upd.v4_group_value  = 10'd0;
         upd.v4_leading_zero = 1'b0;
      end else if (ipv_pkg::is_dec(char_in)) begin
         if ((state_ff.v4_group_len == 3'd0) && (char_in == ipv_pkg::CHAR_ZERO)) begin
            upd.v4_leading_zero = 1'b1;
         end
         if (state_ff.v4_group_len < ipv_pkg::V4_LEN_MAX) begin
            upd.v4_group_value = {state_ff.v4_group_value[6:0], 3'b000}
                                 + {state_ff.v4_group_value[8:0], 1'b0}
                                 + {6'd0, digit};
         end
         if (state_ff.v4_group_len < ipv_pkg::V4_LEN_SAT) begin
            upd.v4_group_len = state_ff.v4_group_len + 3'd1;
         end
      end else begin
         upd.v4_bad = 1'b1;
      end

      if (char_in == ipv_pkg::CHAR_COLON) begin
         if (state_ff.colon_count < ipv_pkg::COLON_SAT) begin
            upd.colon_count = state_ff.colon_count + 4'd1;
         end
         upd.v6_bad       = state_ff.v6_bad | ipv_pkg::v6_group_bad(state_ff.v6_group_len);
         upd.v6_group_len = 3'd0;
      end else if (ipv_pkg::is_hex(char_in)) begin
         if (state_ff.v6_group_len < ipv_pkg::V6_LEN_SAT) begin
            upd.v6_group_len = state_ff.v6_group_len + 3'd1;
         end
      end else begin
         upd.v6_bad = 1'b1;
      end
   end

   assign v4_bad_final = upd.v4_bad | ipv_pkg::v4_group_bad(upd.v4_group_len,
                                                            upd.v4_leading_zero,
                                                            upd.v4_group_value);
   assign v6_bad_final = upd.v6_bad | ipv_pkg::v6_group_bad(upd.v6_group_len);

   always_comb begin
      kind = ipv_pkg::KIND_NONE;
      if (upd.seen_dot) begin
         if ((upd.dot_count == ipv_pkg::DOT_GOOD) && !v4_bad_final) begin
            kind = ipv_pkg::KIND_V4;
         end
      end else if ((upd.colon_count == ipv_pkg::COLON_GOOD) && !v6_bad_final) begin
         kind = ipv_pkg::KIND_V6;
      end
   end

   always_comb begin
      state_in = state_ff;
      if (step_en) begin
         state_in = is_last ? '0 : upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/ip_address_text_validator.sv
// Top level of the IPv4 / IPv6 address text validator.
// Usage:
//   Request channel (req_valid / req_ready) carries one text byte per beat in
//   req_char_in, with req_is_last high on the final byte of a string.
//   Response channel (rsp_valid / rsp_ready) carries one rsp_kind beat per
//   string: 0 neither, 1 valid IPv4, 2 valid IPv6. Bytes without the last
//   flag produce no response beat.
//   The last byte passes the input register, then the result register, before
//   rsp_valid rises; a stalled response can hold it in the input register.
//   Throughput: one byte per cycle while req_ready is high; the scan state is a
//   single register set updated by one pass of counter and compare logic per byte.
//   Reset clears the scan state and both valid flags; req_ready is high in
//   the cycle after reset.
//   When the receiver stalls, the response is held; non-last bytes keep
//   flowing, and a last byte waits in the input register, which then lowers
//   req_ready until the result register frees.
//   All scan state clears after each final byte.
module ip_address_text_validator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ipv_pkg::CHAR_W-1:0]     req_char_in,
   input  logic                           req_is_last,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ipv_pkg::KIND_W-1:0]     rsp_kind
);

   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic [ipv_pkg::CHAR_W-1:0]     in_char_ff;
   logic                           in_last_ff;
   logic                           out_valid_ff;
   logic                           out_valid_in;
   logic [ipv_pkg::KIND_W-1:0]     out_kind_ff;
   logic [ipv_pkg::KIND_W-1:0]     scan_kind;
   logic                           out_free;
   logic                           advance;
   logic                           req_take;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = (advance && in_last_ff) || (out_valid_ff && !rsp_ready);

   ipv_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .char_in (in_char_ff),
      .is_last (in_last_ff),
      .kind    (scan_kind)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_char_ff <= req_char_in;
         in_last_ff <= req_is_last;
      end
      if (advance && in_last_ff) begin
         out_kind_ff <= scan_kind;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;

endmodule

### sv/ipv_checker.sv
// Port-level checks for the address text validator, bound to the top level.
module ipv_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ipv_pkg::KIND_W-1:0]     rsp_kind
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("valid flags not cleared by reset");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == ipv_pkg::KIND_NONE) || (rsp_kind == ipv_pkg::KIND_V4)
                     || (rsp_kind == ipv_pkg::KIND_V6)))
      else $error("illegal kind code on response beat");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled without a blocked response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind)))
      else $error("stalled response beat dropped or changed");

endmodule

bind ip_address_text_validator ipv_checker u_ipv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_kind  (rsp_kind)
);
